// ===== hdl/morse_code_keyer_core_assert.svh =====
// Assertion macros shared by the keyer checker.
`ifndef MORSE_CODE_KEYER_CORE_ASSERT_SVH
`define MORSE_CODE_KEYER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCK_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mck_pkg.sv =====
// Types, constants and the character code table of the keyer.
package mck_pkg;

   localparam int unsigned TIME_W = 16;
   localparam int unsigned PAT_W  = 6;
   localparam int unsigned LEN_W  = 3;
   localparam int unsigned IDX_W  = 3;

   localparam logic [IDX_W-1:0] CSR_DOT_TIME    = 3'd0;
   localparam logic [IDX_W-1:0] CSR_DASH_TIME   = 3'd1;
   localparam logic [IDX_W-1:0] CSR_ELEMENT_GAP = 3'd2;
   localparam logic [IDX_W-1:0] CSR_CHAR_GAP    = 3'd3;
   localparam logic [IDX_W-1:0] CSR_WORD_GAP    = 3'd4;

   localparam logic [TIME_W-1:0] RST_DOT_TIME    = 16'd200;
   localparam logic [TIME_W-1:0] RST_DASH_TIME   = 16'd600;
   localparam logic [TIME_W-1:0] RST_ELEMENT_GAP = 16'd200;
   localparam logic [TIME_W-1:0] RST_CHAR_GAP    = 16'd400;
   localparam logic [TIME_W-1:0] RST_WORD_GAP    = 16'd1200;

   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Element patterns, first element in the most significant used bit, 1 = dash.
   localparam logic [4:0] DIGIT_PAT [10] = '{
      5'h1F, 5'h0F, 5'h07, 5'h03, 5'h01, 5'h00, 5'h10, 5'h18, 5'h1C, 5'h1E
   };
   localparam logic [3:0] LETTER_PAT [26] = '{
      4'd1, 4'd8, 4'd10, 4'd4, 4'd0, 4'd2, 4'd6, 4'd0, 4'd0, 4'd7, 4'd5, 4'd4, 4'd3,
      4'd2, 4'd7, 4'd6, 4'd13, 4'd2, 4'd0, 4'd1, 4'd1, 4'd1, 4'd3, 4'd9, 4'd11, 4'd12
   };
   localparam logic [2:0] LETTER_LEN [26] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };

   typedef struct packed {
      logic [PAT_W-1:0] pat;
      logic [LEN_W-1:0] len;
   } code_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ON    = 4'b0010,
      ST_GAP   = 4'b0100,
      ST_FINAL = 4'b1000
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic take_char;
      logic emit_on;
      logic emit_gap;
      logic emit_final;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_space;
      logic no_elems;
      logic last_elem;
      logic out_free;
   } status_type;

   // Pattern and element count of a character; unknown characters give len 0.
   function automatic code_type lookup_char(input logic [7:0] ch);
      code_type   c;
      logic [7:0] up;
      logic [7:0] ofs;
      begin
         c   = '0;
         up  = ch;
         ofs = '0;
         if (ch >= 8'h61 && ch <= 8'h7A) begin
            up = ch - 8'd32;
         end
         if (ch >= 8'h30 && ch <= 8'h39) begin
            ofs   = ch - 8'h30;
            c.pat = {1'b0, DIGIT_PAT[ofs[3:0]]};
            c.len = 3'd5;
         end else if (up >= 8'h41 && up <= 8'h5A) begin
            ofs   = up - 8'h41;
            c.pat = {2'b00, LETTER_PAT[ofs[4:0]]};
            c.len = LETTER_LEN[ofs[4:0]];
         end else begin
            case (ch)
               8'h2E: c = '{pat: 6'h15, len: 3'd6};
               8'h2C: c = '{pat: 6'h33, len: 3'd6};
               8'h3F: c = '{pat: 6'h0C, len: 3'd6};
               8'h21: c = '{pat: 6'h2B, len: 3'd6};
               8'h2D: c = '{pat: 6'h21, len: 3'd6};
               8'h40: c = '{pat: 6'h1A, len: 3'd6};
               8'h29: c = '{pat: 6'h2D, len: 3'd6};
               8'h2F: c = '{pat: 6'h12, len: 3'd5};
               8'h28: c = '{pat: 6'h16, len: 3'd5};
               default: c = '0;
            endcase
         end
         return c;
      end
   endfunction

endpackage

// ===== hdl/mck_ctrl.sv =====
// Sequencer that walks one character through its segments.
module mck_ctrl
   import mck_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_char = 1'b1;
               state_in      = ST_ON;
            end
         end
         ST_ON: begin
            // space and unknown characters go straight to their closing gap
            if (status.is_space || status.no_elems) begin
               state_in = ST_FINAL;
            end else if (status.out_free) begin
               cmd.emit_on = 1'b1;
               state_in    = ST_GAP;
            end
         end
         ST_GAP: begin
            if (status.out_free) begin
               cmd.emit_gap = 1'b1;
               state_in     = status.last_elem ? ST_FINAL : ST_ON;
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== hdl/mck_dp.sv =====
// Timing registers, character pattern shifter and result register.
module mck_dp
   import mck_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [TIME_W-1:0] csr_write_data,
   input  logic [7:0]        req_char_code,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic              rsp_light_on,
   output logic [TIME_W-1:0] rsp_duration,
   output logic              rsp_last,
   input  cmd_type           cmd,
   output status_type        status
);

   logic [TIME_W-1:0] dot_time_ff, dash_time_ff, element_gap_ff, char_gap_ff, word_gap_ff;
   logic              space_ff;
   logic [PAT_W-1:0]  pat_ff, pat_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              light_on_ff;
   logic [TIME_W-1:0] duration_ff;
   logic              last_ff;
   code_type          code;
   logic [LEN_W-1:0]  shift_amt;
   logic              emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_time_ff    <= RST_DOT_TIME;
         dash_time_ff   <= RST_DASH_TIME;
         element_gap_ff <= RST_ELEMENT_GAP;
         char_gap_ff    <= RST_CHAR_GAP;
         word_gap_ff    <= RST_WORD_GAP;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DOT_TIME:    dot_time_ff    <= csr_write_data;
            CSR_DASH_TIME:   dash_time_ff   <= csr_write_data;
            CSR_ELEMENT_GAP: element_gap_ff <= csr_write_data;
            CSR_CHAR_GAP:    char_gap_ff    <= csr_write_data;
            CSR_WORD_GAP:    word_gap_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Left-align the pattern so the next element is always the top bit.
   always_comb begin
      code      = lookup_char(req_char_code);
      shift_amt = LEN_W'(PAT_W) - code.len;
      pat_in    = pat_ff;
      count_in  = count_ff;
      if (cmd.take_char) begin
         pat_in   = code.pat << shift_amt;
         count_in = code.len;
      end else if (cmd.emit_gap) begin
         pat_in   = {pat_ff[PAT_W-2:0], 1'b0};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff   <= pat_in;
      count_ff <= count_in;
      if (cmd.take_char) begin
         space_ff <= (req_char_code == CHAR_SPACE);
      end
   end

   assign emit = cmd.emit_on | cmd.emit_gap | cmd.emit_final;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         light_on_ff <= cmd.emit_on;
         last_ff     <= cmd.emit_final;
         if (cmd.emit_on) begin
            duration_ff <= pat_ff[PAT_W-1] ? dash_time_ff : dot_time_ff;
         end else if (cmd.emit_gap) begin
            duration_ff <= element_gap_ff;
         end else begin
            duration_ff <= space_ff ? word_gap_ff : char_gap_ff;
         end
      end
   end

   assign status.is_space  = space_ff;
   assign status.no_elems  = (count_ff == '0);
   assign status.last_elem = (count_ff == LEN_W'(1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_light_on = light_on_ff;
   assign rsp_duration = duration_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== hdl/morse_code_keyer_core.sv =====
// Morse keyer: one ASCII character in, light/dark keying segments out.
//
// Input beats carry req_char_code; the block takes one when req_valid is
// high and req_stall low, then holds req_stall high until the character's
// last segment has been loaded into the result register. Result beats carry
// rsp_light_on, rsp_duration (ms) and rsp_last, which marks the final segment
// of a character. A letter of n elements gives 2n+1 beats; a space or an
// unknown character gives one.
// The sequencer loads an input beat into the pattern shifter and enters ON,
// where the first segment is registered into the result register; a space or
// an unknown character passes on to FINAL before its one segment is registered.
// The sequencer emits one segment per cycle into a single result register
// while rsp_stall is low. The next character is taken while the final segment
// still waits downstream.
// When rsp_stall is high the result register holds and the sequencer waits.
// Reset (synchronous) restores the five timing registers to 200/600/200/
// 400/1200 ms, empties the result register and returns to idle.
// Timing registers are to be written through csr_* only while the block is idle; the block does not enforce it.
module morse_code_keyer_core
   import mck_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [TIME_W-1:0] csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_char_code,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_light_on,
   output logic [TIME_W-1:0] rsp_duration,
   output logic              rsp_last
);

   cmd_type    cmd;
   status_type status;

   mck_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mck_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_char_code    (req_char_code),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_light_on     (rsp_light_on),
      .rsp_duration     (rsp_duration),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== hdl/mck_checker.sv =====
// Port-level checks for the keyer, bound to the top level.
`include "morse_code_keyer_core_assert.svh"

module mck_checker
   import mck_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_light_on,
   input logic [TIME_W-1:0] rsp_duration,
   input logic              rsp_last
);

   `MCK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_light_on) && $stable(rsp_duration) && $stable(rsp_last),
      "stalled result beat changed")

   `MCK_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall,
      "input taken twice in a row")

   `MCK_ASSERT_SAME(a_no_take_mid_char, clock, reset, rsp_valid && !rsp_last, req_stall,
      "new character taken before last segment")

   `MCK_ASSERT_SAME(a_light_not_last, clock, reset, rsp_valid && rsp_light_on, !rsp_last,
      "light-on segment marked last")

endmodule

bind morse_code_keyer_core mck_checker u_mck_checker (.*);
